/* design/assert_macros.svh */
// assertion macros used by the solver top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// property checked at every clock edge, reset included
`define ASSERT_ANY(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ANY(lbl, clk, prop)
`endif
`endif

/* design/kea_pkg.sv */
// shared types, constants and tables of the eccentric anomaly solver
`timescale 1ns / 1ps
package kea_pkg;

   localparam int WORK_BITS     = 30;
   localparam int EST_W         = 48;
   localparam int MAG_W         = 47;
   localparam int ANG_W         = 36;
   localparam int CORDIC_STAGES = 30;
   localparam int MOD_STEPS     = 14;
   localparam int DIV_BITS      = 32;
   localparam int DEN_W         = 33;
   localparam int REM_W         = 36;
   localparam int F_W           = 50;
   localparam int PROD_W        = ANG_W + 17;
   localparam int EC_W          = ANG_W + 1;
   localparam int D_W           = ANG_W + 2;

   localparam int NEWTON_STEPS_DEFAULT        = 5;
   localparam int ANGLE_FRACTION_BITS_DEFAULT = 28;

   // sincos: abs, range steps, fold, rotations, sign fix
   localparam int SC_LAT     = 1 + MOD_STEPS + 1 + CORDIC_STAGES + 1;
   localparam int NEWTON_LAT = SC_LAT + 3 + DIV_BITS + 1;

   typedef logic signed [EST_W-1:0] est_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   localparam ang_type PI_ANG      = ANG_W'(64'sd3373259426);
   localparam ang_type HALF_PI_ANG = ANG_W'(64'sd1686629713);
   localparam ang_type TWO_PI_ANG  = ANG_W'(64'sd6746518852);
   localparam ang_type GAIN_ANG    = ANG_W'(64'sd652032874);
   localparam logic signed [D_W-1:0] ONE_D = D_W'(64'sd1073741824);
   localparam mag_type TWO_PI_MAG  = MAG_W'(64'd6746518852);
   localparam logic [DIV_BITS-1:0] PI_QUO = DIV_BITS'(64'd3373259426);
   localparam logic signed [EST_W:0] EST_LIMIT = (EST_W+1)'(64'sd70368744177664);

   typedef struct packed {
      est_type     est;
      est_type     m;
      logic [15:0] e;
      logic        skip;
   } stage_type;

   function automatic ang_type atan_q30(input int idx);
      ang_type v;
      case (idx)
         0:  v = ANG_W'(64'sd843314856);
         1:  v = ANG_W'(64'sd497837829);
         2:  v = ANG_W'(64'sd263043836);
         3:  v = ANG_W'(64'sd133525158);
         4:  v = ANG_W'(64'sd67021686);
         5:  v = ANG_W'(64'sd33543515);
         6:  v = ANG_W'(64'sd16775850);
         7:  v = ANG_W'(64'sd8388437);
         8:  v = ANG_W'(64'sd4194282);
         9:  v = ANG_W'(64'sd2097149);
         10: v = ANG_W'(64'sd1048575);
         11: v = ANG_W'(64'sd524287);
         12: v = ANG_W'(64'sd262143);
         13: v = ANG_W'(64'sd131071);
         14: v = ANG_W'(64'sd65535);
         15: v = ANG_W'(64'sd32767);
         16: v = ANG_W'(64'sd16383);
         17: v = ANG_W'(64'sd8191);
         18: v = ANG_W'(64'sd4095);
         19: v = ANG_W'(64'sd2047);
         20: v = ANG_W'(64'sd1023);
         21: v = ANG_W'(64'sd511);
         22: v = ANG_W'(64'sd255);
         23: v = ANG_W'(64'sd127);
         24: v = ANG_W'(64'sd63);
         25: v = ANG_W'(64'sd31);
         26: v = ANG_W'(64'sd15);
         27: v = ANG_W'(64'sd7);
         28: v = ANG_W'(64'sd3);
         29: v = ANG_W'(64'sd1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/kea_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps
interface kea_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] mean_anomaly;
   logic [15:0]        eccentricity;
   modport source (output valid, mean_anomaly, eccentricity, input ready);
   modport sink (input valid, mean_anomaly, eccentricity, output ready);
endinterface

interface kea_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] eccentric_anomaly;
   logic               derivative_zero;
   modport source (output valid, eccentric_anomaly, derivative_zero, input ready);
   modport sink (input valid, eccentric_anomaly, derivative_zero, output ready);
endinterface

/* design/kea_sincos.sv */
// pipelined sine and cosine: range reduction and rotation cordic
`timescale 1ns / 1ps
module kea_sincos import kea_pkg::*; (
   input  logic    clock,
   input  logic    advance,
   input  est_type angle,
   output ang_type sin_out,
   output ang_type cos_out
);

   mag_type mag_ff [MOD_STEPS+1];
   logic    neg_ff [MOD_STEPS+1];
   ang_type x_ff [CORDIC_STAGES+1];
   ang_type y_ff [CORDIC_STAGES+1];
   ang_type z_ff [CORDIC_STAGES+1];
   logic    flip_ff [CORDIC_STAGES+1];
   ang_type sin_ff, cos_ff;
   est_type abs_in;
   ang_type r0, r1, r2;
   logic    flip_in;

   assign abs_in = angle[EST_W-1] ? -angle : angle;

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff[0] <= MAG_W'(abs_in);
         neg_ff[0] <= angle[EST_W-1];
      end
   end

   // restoring reduction of the magnitude by multiples of two pi
   for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
      localparam mag_type STEP = TWO_PI_MAG << (MOD_STEPS - 1 - k);
      always_ff @(posedge clock) begin
         if (advance) begin
            mag_ff[k+1] <= (mag_ff[k] >= STEP) ? mag_ff[k] - STEP : mag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // fold into -pi/2 .. pi/2
   always_comb begin
      r0 = $signed(ANG_W'(mag_ff[MOD_STEPS]));
      r1 = neg_ff[MOD_STEPS] ? -r0 : r0;
      if (r1 > PI_ANG) begin
         r1 = r1 - TWO_PI_ANG;
      end else if (r1 < -PI_ANG) begin
         r1 = r1 + TWO_PI_ANG;
      end
      r2 = r1;
      flip_in = 1'b0;
      if (r1 > HALF_PI_ANG) begin
         r2 = r1 - PI_ANG;
         flip_in = 1'b1;
      end else if (r1 < -HALF_PI_ANG) begin
         r2 = r1 + PI_ANG;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= GAIN_ANG;
         y_ff[0]    <= '0;
         z_ff[0]    <= r2;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      localparam ang_type ATAN = atan_q30(i);
      ang_type dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
         cos_ff <= flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

/* design/kea_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module kea_div import kea_pkg::*; (
   input  logic                clock,
   input  logic                advance,
   input  logic [REM_W-1:0]    rem_in,
   input  logic [DEN_W-1:0]    den_in,
   output logic [DIV_BITS-1:0] quo_out
);

   logic [REM_W-1:0]    rem_ff [DIV_BITS+1];
   logic [DEN_W-1:0]    den_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] quo_ff [DIV_BITS+1];

   assign rem_ff[0] = rem_in;
   assign den_ff[0] = den_in;
   assign quo_ff[0] = '0;

   // first two bits are the integer part, the rest shift the remainder
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
      logic [REM_W-1:0] num, cmp;
      logic             take;
      if (i < 2) begin : g_int
         assign num = rem_ff[i];
         assign cmp = REM_W'(den_ff[i]) << (1 - i);
      end else begin : g_frac
         assign num = rem_ff[i] << 1;
         assign cmp = REM_W'(den_ff[i]);
      end
      assign take = num >= cmp;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= take ? num - cmp : num;
            den_ff[i+1] <= den_ff[i];
            quo_ff[i+1] <= {quo_ff[i][DIV_BITS-2:0], take};
         end
      end
   end

   assign quo_out = quo_ff[DIV_BITS];

endmodule

/* design/kea_newton.sv */
// one pipelined newton-raphson step on the eccentric anomaly estimate
`timescale 1ns / 1ps
module kea_newton import kea_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  stage_type in_item,
   output logic      out_valid,
   output stage_type out_item
);

   typedef struct packed {
      stage_type item;
      logic      neg;
      logic      sat;
      logic      dz;
   } div_side_type;

   logic         valid_ff [NEWTON_LAT];
   stage_type    sc_line_ff [SC_LAT];
   div_side_type div_line_ff [DIV_BITS+1];
   ang_type      sin_w, cos_w;
   logic signed [PROD_W-1:0] prod_s, prod_c;
   logic signed [EC_W-1:0]   es_ff, ec_ff;
   stage_type    p1_ff, p2_ff;
   logic signed [F_W-1:0]    f_ff, f_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic [F_W-1:0]           mag;
   logic [DEN_W-1:0]         den_ff;
   logic [REM_W-1:0]         rem_ff;
   div_side_type             p3_in;
   logic [DIV_BITS-1:0]      quo;
   logic [DIV_BITS-1:0]      step_mag;
   logic signed [DIV_BITS+1:0] step;
   logic signed [EST_W:0]    next_est;
   stage_type                out_in, out_ff;
   div_side_type             dv;

   kea_sincos u_sincos (
      .clock   (clock),
      .advance (advance),
      .angle   (in_item.est),
      .sin_out (sin_w),
      .cos_out (cos_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NEWTON_LAT; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NEWTON_LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // side data rides along with the sincos pipe
   always_ff @(posedge clock) begin
      if (advance) begin
         sc_line_ff[0] <= in_item;
         for (int i = 1; i < SC_LAT; i++) sc_line_ff[i] <= sc_line_ff[i-1];
      end
   end

   assign prod_s = $signed({1'b0, sc_line_ff[SC_LAT-1].e}) * sin_w;
   assign prod_c = $signed({1'b0, sc_line_ff[SC_LAT-1].e}) * cos_w;

   // floor of the products by 2^16
   always_ff @(posedge clock) begin
      if (advance) begin
         es_ff <= prod_s[PROD_W-1:16];
         ec_ff <= prod_c[PROD_W-1:16];
         p1_ff <= sc_line_ff[SC_LAT-1];
      end
   end

   assign f_in = F_W'(p1_ff.est) - F_W'(es_ff) - F_W'(p1_ff.m);
   assign d_in = ONE_D - D_W'(ec_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         f_ff  <= f_in;
         d_ff  <= d_in;
         p2_ff <= p1_ff;
      end
   end

   // quotient of four or more saturates at pi anyway
   always_comb begin
      mag        = f_ff[F_W-1] ? F_W'(-f_ff) : F_W'(f_ff);
      p3_in.item = p2_ff;
      p3_in.neg  = f_ff[F_W-1];
      p3_in.sat  = mag >= F_W'({DEN_W'(d_ff), 2'b00});
      p3_in.dz   = d_ff <= 0;
   end

   // side data waits as long as the divider pipe
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff         <= DEN_W'(d_ff);
         rem_ff         <= p3_in.sat ? '0 : REM_W'(mag);
         div_line_ff[0] <= p3_in;
         for (int i = 1; i <= DIV_BITS; i++) div_line_ff[i] <= div_line_ff[i-1];
      end
   end

   kea_div u_div (
      .clock   (clock),
      .advance (advance),
      .rem_in  (rem_ff),
      .den_in  (den_ff),
      .quo_out (quo)
   );

   always_comb begin
      dv       = div_line_ff[DIV_BITS];
      step_mag = (dv.sat || quo > PI_QUO) ? PI_QUO : quo;
      step     = dv.neg ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
      next_est = (EST_W+1)'(dv.item.est) - (EST_W+1)'(step);
      if (next_est > EST_LIMIT) begin
         next_est = EST_LIMIT;
      end else if (next_est < -EST_LIMIT) begin
         next_est = -EST_LIMIT;
      end
      out_in = dv.item;
      if (dv.dz) begin
         out_in.skip = 1'b1;
      end else begin
         out_in.est = EST_W'(next_est);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[NEWTON_LAT-1];
   assign out_item  = out_ff;

endmodule

/* design/kepler_eccentric_anomaly_solver.sv */
// kepler equation solver: fixed count of newton-raphson steps, fully pipelined
// one word per cycle while the response word is not stalled
// each step is sincos (47) + products, residual, magnitude (3) + divider (32) + update (1)
// the whole pipe stalls as one while the response word waits to be taken
// synchronous active-high reset clears all valid bits, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kepler_eccentric_anomaly_solver import kea_pkg::*; #(
   parameter int NEWTON_STEPS        = NEWTON_STEPS_DEFAULT,
   parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   kea_req_if.sink   req_if,
   kea_rsp_if.source rsp_if
);

   localparam int RES_W = EST_W + 12;

   logic      advance;
   logic      in_valid_ff;
   stage_type in_ff;
   est_type   m_in;
   logic      chain_valid [NEWTON_STEPS+1];
   stage_type chain_item  [NEWTON_STEPS+1];
   logic signed [RES_W-1:0] res_wide;
   logic signed [31:0]      res_in;
   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_angle_ff;
   logic                    rsp_zero_ff;

   // every stage moves unless a finished word is stuck at the output
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // convert the input angle to the q30 working format
   if (ANGLE_FRACTION_BITS > WORK_BITS) begin : g_in_round
      localparam int SH = ANGLE_FRACTION_BITS - WORK_BITS;
      logic signed [33:0] m_sum;
      assign m_sum = 34'(req_if.mean_anomaly) + (34'sd1 <<< (SH - 1));
      assign m_in  = EST_W'(m_sum >>> SH);
   end else begin : g_in_shift
      localparam int SH = WORK_BITS - ANGLE_FRACTION_BITS;
      assign m_in = EST_W'(req_if.mean_anomaly) <<< SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_if.valid;
      end
   end

   // first estimate is the mean anomaly itself
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff.est  <= m_in;
         in_ff.m    <= m_in;
         in_ff.e    <= req_if.eccentricity;
         in_ff.skip <= 1'b0;
      end
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_item[0]  = in_ff;

   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      kea_newton u_newton (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   // back to the output format, round half up when bits are dropped
   if (ANGLE_FRACTION_BITS >= WORK_BITS) begin : g_out_shift
      localparam int SH = ANGLE_FRACTION_BITS - WORK_BITS;
      assign res_wide = RES_W'(chain_item[NEWTON_STEPS].est) <<< SH;
   end else begin : g_out_round
      localparam int SH = WORK_BITS - ANGLE_FRACTION_BITS;
      assign res_wide = (RES_W'(chain_item[NEWTON_STEPS].est) + (RES_W'(1) <<< (SH - 1)))
                        >>> SH;
   end

   // saturate to the 32-bit range
   always_comb begin
      if (res_wide > RES_W'(32'sh7fffffff)) begin
         res_in = 32'sh7fffffff;
      end else if (res_wide < RES_W'(-33'sd2147483648)) begin
         res_in = 32'sh80000000;
      end else begin
         res_in = res_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[NEWTON_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_angle_ff <= res_in;
         rsp_zero_ff  <= chain_item[NEWTON_STEPS].skip;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.eccentric_anomaly = rsp_angle_ff;
   assign rsp_if.derivative_zero   = rsp_zero_ff;

   // nothing comes out in the cycle after reset
   `ASSERT_ANY(a_reset_empty, clock, $past(reset) |-> !rsp_valid_ff)
   // no new word is taken while the output word is stalled
   `ASSERT_CLK(a_stall_blocks, clock, reset, (rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
   // an accepted word shows up in the first stage
   `ASSERT_CLK(a_accept_lands, clock, reset, (req_if.valid && req_if.ready) |=> in_valid_ff)
   // a finished word that may move reaches the output register
   `ASSERT_CLK(a_last_lands, clock, reset, (advance && chain_valid[NEWTON_STEPS]) |=> rsp_valid_ff)

endmodule

/* tb/sv/tb_kepler_eccentric_anomaly_solver.sv */
// self-checking testbench for the kepler eccentric anomaly solver
`timescale 1ns / 1ps
module tb_kepler_eccentric_anomaly_solver;
   import kea_pkg::*;

   // fixed-point constants of the solver, all in q30
   localparam longint ONE_Q30      = 64'sd1073741824;
   localparam longint PI_Q30       = 64'sd3373259426;
   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam longint TWO_PI_Q30   = 64'sd6746518852;
   localparam longint CORDIC_GAIN  = 64'sd652032874;
   localparam longint EST_CLAMP    = 64'sd1 << 46;
   localparam int     STEPS        = NEWTON_STEPS_DEFAULT;
   localparam int     FRAC_BITS    = ANGLE_FRACTION_BITS_DEFAULT;
   localparam int     ROTATIONS    = 30;
   // pipe depth is 2 + 83 per newton step
   localparam int     PIPE_DEPTH   = 2 + STEPS * 83;
   // idle cycles tolerated: pipe fill plus the long receiver hold-off, several times over
   localparam int     IDLE_LIMIT   = 12000;
   localparam int     LONG_HOLD    = 1500;

   typedef struct {
      logic signed [31:0] anomaly;
      logic               deriv_zero;
   } solution_type;

   logic clock;
   logic reset;
   kea_req_if req();
   kea_rsp_if rsp();

   kepler_eccentric_anomaly_solver dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req.sink),
      .rsp_if (rsp.source)
   );

   longint       arctan_q30 [ROTATIONS];
   solution_type solutions_due [$];
   int        error_count;
   int        idle_cycles;
   int        hold_request;
   bit        no_stall;       // receiver ready while set, unless a hold-off is pending
   bit        no_gaps;        // sender streams back to back while set
   int        burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // solution predictor
   // ---------------------------------------------------------------

   // sine and cosine of a q30 angle via range fold and 30 cordic rotations
   task automatic sincos_q30(input longint angle, output longint s, output longint c);
      longint r, x, y, dx, dy;
      bit     flip;
      r = angle % TWO_PI_Q30;
      flip = 1'b0;
      x = CORDIC_GAIN;
      y = 0;
      if (r > PI_Q30) r -= TWO_PI_Q30;
      if (r < -PI_Q30) r += TWO_PI_Q30;
      if (r > HALF_PI_Q30) begin
         r -= PI_Q30;
         flip = 1'b1;
      end else if (r < -HALF_PI_Q30) begin
         r += PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (r >= 0) begin
            x -= dx; y += dy; r -= arctan_q30[i];
         end else begin
            x += dx; y -= dy; r += arctan_q30[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   // newton correction f / d in q30, magnitude limited to pi, truncated toward zero
   function automatic longint newton_correction(input longint f, input longint d);
      longint unsigned mag, q, r, v;
      longint          res;
      mag = (f < 0) ? longint'(-f) : longint'(f);
      q = mag / longint'(d);
      r = mag % longint'(d);
      if (q >= 4) res = PI_Q30;
      else begin
         v = (q << 30) + ((r << 30) / longint'(d));
         res = longint'(v);
         if (res > PI_Q30) res = PI_Q30;
      end
      return (f < 0) ? -res : res;
   endfunction

   task automatic solve_kepler(input logic signed [31:0] mean, input logic [15:0] ecc,
                               output solution_type sol);
      longint m, est, s, c, f, d, e, res;
      bit     skipped;
      e = longint'(ecc);
      m = longint'(mean) <<< (30 - FRAC_BITS);
      est = m;
      skipped = 1'b0;
      for (int k = 0; k < STEPS; k++) begin
         sincos_q30(est, s, c);
         f = est - ((e * s) >>> 16) - m;
         d = ONE_Q30 - ((e * c) >>> 16);
         if (d <= 0) skipped = 1'b1;
         else begin
            est = est - newton_correction(f, d);
            if (est > EST_CLAMP) est = EST_CLAMP;
            if (est < -EST_CLAMP) est = -EST_CLAMP;
         end
      end
      // back to output format, rounding half up
      res = (est + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      sol.anomaly = res[31:0];
      sol.deriv_zero = skipped;
   endtask

   // ---------------------------------------------------------------
   // sender: one request word, bursts with random gaps
   // ---------------------------------------------------------------
   task automatic send_word(input logic signed [31:0] mean, input logic [15:0] ecc);
      solution_type sol;
      int        gap;
      if (!no_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req.valid        <= 1'b1;
      req.mean_anomaly <= mean;
      req.eccentricity <= ecc;
      // ready is stable by the falling edge; the word goes on the next rising edge
      do @(negedge clock); while (!req.ready);
      @(posedge clock);
      solve_kepler(mean, ecc, sol);
      solutions_due.push_back(sol);
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // receiver stall pattern and long hold-off
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_request > 0) begin
         rsp.ready <= 1'b0;
         hold_request <= hold_request - 1;
      end else if (no_stall) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 9) > 2);
   end

   // ---------------------------------------------------------------
   // response checker and idle watchdog, sampled mid-cycle
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      solution_type want;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            if (solutions_due.size() == 0) begin
               $error("unexpected response word: eccentric_anomaly=%0d derivative_zero=%0b",
                      rsp.eccentric_anomaly, rsp.derivative_zero);
               error_count++;
            end else begin
               want = solutions_due.pop_front();
               if (rsp.eccentric_anomaly !== want.anomaly) begin
                  $error("eccentric_anomaly: expected %0d, actual %0d",
                         want.anomaly, rsp.eccentric_anomaly);
                  error_count++;
               end
               if (rsp.derivative_zero !== want.deriv_zero) begin
                  $error("derivative_zero: expected %0b, actual %0b",
                         want.deriv_zero, rsp.derivative_zero);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // field extremes, output saturation, zero and near-one eccentricity
   task automatic test_directed();
      logic signed [31:0] means [8];
      logic [15:0]        eccs [3];
      means = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                32'sd843314856, -32'sd843314856, 32'sh55555555};
      eccs = '{16'd0, 16'hffff, 16'h8000};
      foreach (means[i])
         foreach (eccs[j])
            if (i * 3 + j < 24) send_word(means[i], eccs[j]);
      end_burst();
   endtask

   // full-range random words; every bit of both fields toggles
   task automatic test_random_full(input int count);
      for (int i = 0; i < count; i++)
         send_word($urandom, $urandom_range(0, 65535));
      end_burst();
   endtask

   // angles within one turn, half of them with high eccentricity, where newton does real work
   task automatic test_orbits(input int count);
      logic signed [31:0] mean;
      logic [15:0]        ecc;
      for (int i = 0; i < count; i++) begin
         mean = $signed($urandom_range(0, 32'h6487ed51)) - 32'sh3243f6a8;
         ecc = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(60000, 65535))
                                           : 16'($urandom_range(0, 65535));
         send_word(mean, ecc);
      end
      end_burst();
   endtask

   // back-to-back words while the receiver holds off, so the pipe fills and stalls
   task automatic test_backpressure(input int count);
      no_gaps = 1'b1;
      hold_request = LONG_HOLD;
      test_random_full(count);
      no_gaps = 1'b0;
   endtask

   // no idling on either side
   task automatic test_streaming(input int count);
      no_gaps = 1'b1;
      no_stall = 1'b1;
      test_orbits(count);
      no_gaps = 1'b0;
      no_stall = 1'b0;
   endtask

   initial begin
      arctan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                     131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                     127, 63, 31, 15, 7, 3, 1};
      error_count = 0;
      idle_cycles = 0;
      hold_request = 0;
      no_stall = 1'b0;
      no_gaps = 1'b0;
      burst_left = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.mean_anomaly = '0;
      req.eccentricity = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_full(200);
      test_backpressure(600);
      test_orbits(200);
      test_streaming(126);

      // drain the pipe, then allow for its depth
      while (solutions_due.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
